// ===== sv/rest_pkg.sv =====
`timescale 1ns / 1ps
// rest_pkg: shared types and register codes for the radial erf source taper
// no dependencies

package rest_pkg;

    // register byte address index (paddr[4:2])
    typedef enum logic [2:0] {
        REG_SOURCE_COL      = 3'd0,
        REG_SOURCE_ROW      = 3'd1,
        REG_ZERO_HALF_WIDTH = 3'd2,
        REG_DISTANCE_SCALE  = 3'd3,
        REG_TAPER_ENABLE    = 3'd4
    } rest_reg_t;

    localparam int unsigned ADDR_BITS   = 5;
    localparam int unsigned SAMPLE_BITS = 32;
    localparam int unsigned INDEX_BITS  = 12;
    localparam int unsigned WOUT_BITS   = 16;
    localparam int unsigned ARG_FRAC    = 16;
    // interpolation fraction bits: arg (q.16) times entries over four
    localparam int unsigned FRAC_BITS   = 18;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [INDEX_BITS-1:0]         col_index;
        logic [INDEX_BITS-1:0]         row_index;
    } rest_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] tapered_sample;
        logic [WOUT_BITS-1:0]          weight;
    } rest_out_t;

    // side data carried alongside the root through the cells
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          zero;
    } rest_side_t;

endpackage

// ===== sv/radial_erf_source_taper.sv =====
`timescale 1ns / 1ps
// radial_erf_source_taper: top level, config registers, pipeline and output skid
// depends on rest_pkg, rest_sqrt_cell, rest_erf_rom
//
//  channel | signals                      | moves
//  in      | in_valid, in_stall, in_data  | one sample with column and row
//  out     | out_valid, out_stall, out_data | tapered sample and weight
//  cfg     | psel..pready (apb)           | register reads and writes
//
// one transaction per cycle sustained while the output is not stalled; the pipeline
// is the row of square root cells (one cell per root bit, COORD_BITS + 9) plus the input,
// square, distance, scale, lookup, interpolate, product and output stages.
// reset clears the registers to their defaults and empties the pipeline.
// a stalled output parks one result in a skid register; in_stall rises only then.

module radial_erf_source_taper #(
    parameter int unsigned COORD_BITS        = 12,
    parameter int unsigned ERF_TABLE_ENTRIES = 256,
    parameter int unsigned WEIGHT_FRAC_BITS  = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rest_pkg::rest_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rest_pkg::rest_out_t               out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rest_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import rest_pkg::*;

    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned WF   = WEIGHT_FRAC_BITS;
    localparam int unsigned DW   = 2 * CB + 1;
    localparam int unsigned CW   = (DW > 16) ? DW : 16;
    localparam int unsigned RB   = CB + 9;
    localparam int unsigned IW   = $clog2(ERF_TABLE_ENTRIES + 1);
    localparam int unsigned PW   = FRAC_BITS + IW;
    localparam int unsigned AW   = RB + 24 - 8;
    localparam logic [WF:0] ONE  = (WF+1)'(1) << WF;

    // ---------------- configuration ----------------
    logic [11:0] source_col_reg;
    logic [11:0] source_row_reg;
    logic [7:0]  zero_half_width_reg;
    logic [23:0] distance_scale_reg;
    logic        taper_enable_reg;
    logic        cfg_wr;
    rest_reg_t   cfg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = rest_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_col_reg      <= 12'd0;
            source_row_reg      <= 12'd0;
            zero_half_width_reg <= 8'd1;
            distance_scale_reg  <= 24'd65536;
            taper_enable_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_SOURCE_COL:      source_col_reg      <= pwdata[11:0];
                REG_SOURCE_ROW:      source_row_reg      <= pwdata[11:0];
                REG_ZERO_HALF_WIDTH: zero_half_width_reg <= pwdata[7:0];
                REG_DISTANCE_SCALE:  distance_scale_reg  <= pwdata[23:0];
                REG_TAPER_ENABLE:    taper_enable_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_SOURCE_COL:      prdata = {20'd0, source_col_reg};
            REG_SOURCE_ROW:      prdata = {20'd0, source_row_reg};
            REG_ZERO_HALF_WIDTH: prdata = {24'd0, zero_half_width_reg};
            REG_DISTANCE_SCALE:  prdata = {8'd0, distance_scale_reg};
            REG_TAPER_ENABLE:    prdata = {31'd0, taper_enable_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // stage a: input register
    logic                   a_valid_reg;
    rest_in_t               a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_reg <= in_data;
    end

    // stage b: coordinate differences squared
    logic [CB-1:0]  cm;
    logic [CB-1:0]  rm;
    logic [CB-1:0]  scm;
    logic [CB-1:0]  srm;
    logic [CB-1:0]  adc;
    logic [CB-1:0]  adr;
    logic           b_valid_reg;
    logic [31:0]    b_sample_reg;
    logic [2*CB-1:0] b_sqc_reg;
    logic [2*CB-1:0] b_sqr_reg;

    always_comb
    begin
        cm  = CB'(a_reg.col_index);
        rm  = CB'(a_reg.row_index);
        scm = CB'(source_col_reg);
        srm = CB'(source_row_reg);
        adc = (cm >= scm) ? (cm - scm) : (scm - cm);
        adr = (rm >= srm) ? (rm - srm) : (srm - rm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sample_reg <= a_reg.sample;
            b_sqc_reg    <= adc * adc;
            b_sqr_reg    <= adr * adr;
        end
    end

    // stage c: squared distance and hard zero test
    logic [DW-1:0] d2;
    logic [7:0]    zhw;
    logic [15:0]   zhw2;
    rest_side_t    c_side;
    logic [DW-1:0] c_d2_reg;
    logic          c_valid_reg;
    logic [31:0]   c_sample_reg;
    logic          c_zero_reg;

    always_comb
    begin
        d2   = DW'(b_sqc_reg) + DW'(b_sqr_reg);
        zhw  = (zero_half_width_reg == 8'd0) ? 8'd1 : zero_half_width_reg;
        zhw2 = zhw * zhw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_d2_reg     <= d2;
            c_sample_reg <= b_sample_reg;
            c_zero_reg   <= (CW'(d2) <= CW'(zhw2));
        end
    end

    always_comb
    begin
        c_side.valid  = c_valid_reg;
        c_side.sample = c_sample_reg;
        c_side.zero   = c_zero_reg;
    end

    // ---------------- square root cells ----------------
    rest_side_t      cell_side [0:RB];
    logic [RB+1:0]   cell_rem  [0:RB];
    logic [RB-1:0]   cell_root [0:RB];
    logic [2*RB-1:0] cell_rad  [0:RB];

    assign cell_side[0] = c_side;
    assign cell_rem[0]  = '0;
    assign cell_root[0] = '0;
    assign cell_rad[0]  = {1'b0, c_d2_reg, 16'd0};

    for (genvar g = 0; g < RB; g++)
    begin : g_cell
        rest_sqrt_cell #(
            .RB(RB)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (cell_side[g]),
            .rem_in   (cell_rem[g]),
            .root_in  (cell_root[g]),
            .rad_in   (cell_rad[g]),
            .side_out (cell_side[g+1]),
            .rem_out  (cell_rem[g+1]),
            .root_out (cell_root[g+1]),
            .rad_out  (cell_rad[g+1])
        );
    end

    // stage m: scaled erf argument, q(COORD_BITS+9).16
    logic [RB+23:0] m_prod;
    logic           m_valid_reg;
    rest_side_t     m_side_reg;
    logic [AW-1:0]  m_arg_reg;

    assign m_prod = cell_root[RB] * distance_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= cell_side[RB].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= cell_side[RB];
            m_arg_reg  <= m_prod[RB+23:8];
        end
    end

    // stage p: table position
    logic [PW-1:0] pos;
    logic          p_valid_reg;
    rest_side_t    p_side_reg;
    logic          p_sat_reg;
    logic [IW-1:0] p_idx_reg;
    logic [FRAC_BITS-1:0] p_frac_reg;

    assign pos = PW'(m_arg_reg[FRAC_BITS-1:0]) * PW'(ERF_TABLE_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= m_side_reg;
            // argument four or more saturates to one
            p_sat_reg  <= (m_arg_reg[AW-1:FRAC_BITS] != '0);
            p_idx_reg  <= pos[PW-1:FRAC_BITS];
            p_frac_reg <= pos[FRAC_BITS-1:0];
        end
    end

    // stage l: table read and slope product
    logic [WF:0]           t_lo;
    logic [WF:0]           t_hi;
    logic [WF:0]           t_diff;
    logic                  l_valid_reg;
    rest_side_t            l_side_reg;
    logic                  l_sat_reg;
    logic                  l_up_reg;
    logic [WF:0]           l_lo_reg;
    logic [WF+FRAC_BITS:0] l_prod_reg;

    rest_erf_rom #(
        .ENTRIES (ERF_TABLE_ENTRIES),
        .WF      (WF),
        .IW      (IW)
    ) u_rom (
        .idx (p_idx_reg),
        .lo  (t_lo),
        .hi  (t_hi)
    );

    assign t_diff = (t_hi >= t_lo) ? (t_hi - t_lo) : (t_lo - t_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_valid_reg <= 1'b0;
        else if (en)
            l_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_side_reg <= p_side_reg;
            l_sat_reg  <= p_sat_reg;
            l_up_reg   <= (t_hi >= t_lo);
            l_lo_reg   <= t_lo;
            l_prod_reg <= t_diff * p_frac_reg;
        end
    end

    // stage w: final weight
    logic [WF+FRAC_BITS:0] adj_full;
    logic [WF:0]           adj;
    logic [WF:0]           w_next;
    logic                  w_valid_reg;
    logic [31:0]           w_sample_reg;
    logic [WF:0]           w_reg;

    always_comb
    begin
        adj_full = (l_prod_reg + (WF+FRAC_BITS+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        adj      = adj_full[WF:0];
        if (!taper_enable_reg)
            w_next = ONE;
        else if (l_side_reg.zero)
            w_next = '0;
        else if (l_sat_reg)
            w_next = ONE;
        else if (l_up_reg)
            w_next = l_lo_reg + adj;
        else
            w_next = l_lo_reg - adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else if (en)
            w_valid_reg <= l_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_sample_reg <= l_side_reg.sample;
            w_reg        <= w_next;
        end
    end

    // stage q: magnitude times weight
    logic [32:0]    mag;
    logic           q_valid_reg;
    logic           q_neg_reg;
    logic [WF:0]    q_w_reg;
    logic [WF+33:0] q_prod_reg;

    assign mag = w_sample_reg[31] ? ({1'b0, ~w_sample_reg} + 33'd1) : {1'b0, w_sample_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (en)
            q_valid_reg <= w_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_neg_reg  <= w_sample_reg[31];
            q_w_reg    <= w_reg;
            q_prod_reg <= mag * w_reg;
        end
    end

    // rounding, ties away from zero on the magnitude
    logic [WF+33:0] rnd;
    logic [31:0]    qv;
    rest_out_t      res;

    always_comb
    begin
        rnd                = (q_prod_reg + (WF+34)'(1 << (WF - 1))) >> WF;
        qv                 = rnd[31:0];
        res.tapered_sample = q_neg_reg ? (32'd0 - qv) : qv;
        res.weight         = WOUT_BITS'(q_w_reg);
    end

    // ---------------- output register and skid ----------------
    logic      out_valid_reg;
    rest_out_t out_reg;
    rest_out_t skid_reg;
    logic      out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
                skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_stall)
            skid_valid_reg <= q_valid_reg;
        else
            out_valid_reg <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
                out_reg <= skid_reg;
        end
        else if (out_valid_reg && out_stall)
            skid_reg <= res;
        else
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/rest_sqrt_cell.sv =====
`timescale 1ns / 1ps
// rest_sqrt_cell: one digit step of the integer square root, registered
// depends on rest_pkg

module rest_sqrt_cell #(
    parameter int unsigned RB = 21
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rest_pkg::rest_side_t   side_in,
    input  logic [RB+1:0]          rem_in,
    input  logic [RB-1:0]          root_in,
    input  logic [2*RB-1:0]        rad_in,
    output rest_pkg::rest_side_t   side_out,
    output logic [RB+1:0]          rem_out,
    output logic [RB-1:0]          root_out,
    output logic [2*RB-1:0]        rad_out
);
    import rest_pkg::*;

    logic [RB+1:0]   remc;
    logic [RB+1:0]   trial;
    logic [RB+1:0]   rem_next;
    logic [RB-1:0]   root_next;
    logic [2*RB-1:0] rad_next;
    logic            side_valid_reg;
    rest_side_t      side_reg;
    logic [RB+1:0]   rem_reg;
    logic [RB-1:0]   root_reg;
    logic [2*RB-1:0] rad_reg;

    always_comb
    begin
        remc  = {rem_in[RB-1:0], rad_in[2*RB-1:2*RB-2]};
        trial = {root_in, 2'b01};
        if (remc >= trial)
        begin
            rem_next  = remc - trial;
            root_next = {root_in[RB-2:0], 1'b1};
        end
        else
        begin
            rem_next  = remc;
            root_next = {root_in[RB-2:0], 1'b0};
        end
        rad_next = {rad_in[2*RB-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_valid_reg <= 1'b0;
        else if (en)
            side_valid_reg <= side_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    always_comb
    begin
        side_out       = side_reg;
        side_out.valid = side_valid_reg;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

// ===== sv/rest_erf_rom.sv =====
`timescale 1ns / 1ps
// rest_erf_rom: erf table built at elaboration, reads two neighboring points
// depends on rest_pkg

module rest_erf_rom #(
    parameter int unsigned ENTRIES = 256,
    parameter int unsigned WF      = 15,
    parameter int unsigned IW      = 9
) (
    input  logic [IW-1:0] idx,
    output logic [WF:0]   lo,
    output logic [WF:0]   hi
);
    import rest_pkg::*;

    localparam int unsigned EW = WF + 1;
    localparam logic [63:0] TWO_OVER_ROOT_PI_Q30 = 64'd1211587905;

    // restoring long division, only evaluated while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        begin
            rem = '0;
            quo = '0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = {rem[63:0], num[i]};
                if (rem >= {1'b0, den})
                begin
                    rem    = rem - {1'b0, den};
                    quo[i] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    function automatic logic [63:0] mul_q24(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p1;
        logic [63:0] p2;
        begin
            p1 = (a >> 24) * b;
            p2 = ((a & 64'hFF_FFFF) * b) >> 24;
            return p1 + p2;
        end
    endfunction

    function automatic logic [WF:0] erf_point(input int unsigned k);
        logic [63:0] ents;
        logic [63:0] kk;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] te;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] ratio;
        logic [63:0] q30;
        logic [63:0] w;
        logic [63:0] one;
        logic        done;
        begin
            ents = 64'(ENTRIES);
            kk   = 64'(k);
            one  = 64'd1 << WF;
            x2   = udiv64((64'd16 * kk * kk) << 24, ents * ents);
            t    = udiv64((64'd4 * kk) << 32, ents);
            te   = 64'd1 << 32;
            s    = t;
            e    = te;
            done = 1'b0;
            for (int n = 1; n < 256; n++)
            begin
                if (!done)
                begin
                    t  = udiv64(mul_q24(t, x2) * 64'd2, 64'd2 * 64'(n) + 64'd1);
                    te = udiv64(mul_q24(te, x2), 64'(n));
                    s  = s + t;
                    e  = e + te;
                    if (t == 64'd0 && te == 64'd0)
                        done = 1'b1;
                end
            end
            for (int j = 0; j < 64; j++)
            begin
                if ((s >> 33) != 64'd0)
                begin
                    s = s >> 1;
                    e = e >> 1;
                end
            end
            ratio = udiv64(s << 30, e);
            q30   = (ratio * TWO_OVER_ROOT_PI_Q30) >> 30;
            if (q30 > (64'd1 << 30))
                q30 = 64'd1 << 30;
            w = (q30 + (64'd1 << (29 - WF))) >> (30 - WF);
            if (w > one)
                w = one;
            return w[WF:0];
        end
    endfunction

    function automatic logic [(ENTRIES+1)*EW-1:0] build_rom();
        logic [(ENTRIES+1)*EW-1:0] r;
        begin
            r = '0;
            for (int unsigned k = 0; k <= ENTRIES; k++)
                r[k*EW +: EW] = erf_point(k);
            return r;
        end
    endfunction

    localparam logic [(ENTRIES+1)*EW-1:0] ROM = build_rom();

    logic [IW-1:0] idx_hi;

    assign idx_hi = idx + IW'(1);
    assign lo     = ROM[idx*EW +: EW];
    assign hi     = ROM[idx_hi*EW +: EW];

endmodule
